@@ rtl/core/srctok_pkg.sv @@
// Shared types, token codes and character class helpers for the source tokenizer.
// No dependencies; used by source_tokenizer.
`default_nettype none

package srctok_pkg;

  localparam int unsigned FieldW = 24;
  localparam logic [FieldW-1:0] FieldMax = 24'hFFFFFF;

  // token kinds
  localparam logic [5:0] KindEnd    = 6'd0;
  localparam logic [5:0] KindString = 6'd21;
  localparam logic [5:0] KindIdent  = 6'd22;
  localparam logic [5:0] KindFor    = 6'd23;
  localparam logic [5:0] KindWhile  = 6'd24;
  localparam logic [5:0] KindReturn = 6'd25;
  localparam logic [5:0] KindDo     = 6'd26;
  localparam logic [5:0] KindNew    = 6'd27;
  localparam logic [5:0] KindDelete = 6'd28;
  localparam logic [5:0] KindNull   = 6'd29;
  localparam logic [5:0] KindBool   = 6'd30;
  localparam logic [5:0] KindInt    = 6'd31;
  localparam logic [5:0] KindFloat  = 6'd32;
  localparam logic [5:0] KindError  = 6'd33;
  localparam logic [5:0] KindNone   = 6'd0;

  // error codes
  localparam logic [1:0] ErrNone       = 2'd0;
  localparam logic [1:0] ErrUnfinished = 2'd1;
  localparam logic [1:0] ErrTwoPeriods = 2'd2;
  localparam logic [1:0] ErrUnexpected = 2'd3;

  typedef enum logic [6:0] {
    ModeIdle   = 7'b0000001,
    ModeIdent  = 7'b0000010,
    ModeNumber = 7'b0000100,
    ModeDstr   = 7'b0001000,
    ModeDesc   = 7'b0010000,
    ModeSstr   = 7'b0100000,
    ModeHalt   = 7'b1000000
  } mode_e;

  typedef struct packed {
    logic [5:0]        kind;
    logic [1:0]        err;
    logic [FieldW-1:0] start;
    logic [FieldW-1:0] len;
    logic [FieldW-1:0] line;
    logic              last;
  } tok_t;

  // keyword text packed first byte lowest
  localparam int unsigned NumWords = 9;
  localparam logic [63:0] WordText [NumWords] = '{
    64'h0000_0000_0072_6f66,  // for
    64'h0000_0065_6c69_6877,  // while
    64'h0000_6e72_7574_6572,  // return
    64'h0000_0000_0000_6f64,  // do
    64'h0000_0000_0077_656e,  // new
    64'h0000_6574_656c_6564,  // delete
    64'h0000_0000_6c6c_756e,  // null
    64'h0000_0000_6575_7274,  // true
    64'h0000_0065_736c_6166   // false
  };
  localparam logic [2:0] WordLen [NumWords] = '{
    3'd3, 3'd5, 3'd6, 3'd2, 3'd3, 3'd6, 3'd4, 3'd4, 3'd5
  };
  localparam logic [5:0] WordKind [NumWords] = '{
    KindFor, KindWhile, KindReturn, KindDo, KindNew, KindDelete, KindNull,
    KindBool, KindBool
  };

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a) || b == 8'h5f;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_eol(input logic [7:0] b);
    return b == 8'h0a || b == 8'h0d;
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0c || b == 8'h0b;
  endfunction

  // punctuator kind, KindNone when the byte is no punctuator
  function automatic logic [5:0] punct_kind(input logic [7:0] b);
    logic [5:0] k;
    unique case (b)
      8'h28:   k = 6'd1;   // (
      8'h29:   k = 6'd2;   // )
      8'h7b:   k = 6'd3;   // {
      8'h7d:   k = 6'd4;   // }
      8'h5b:   k = 6'd5;   // [
      8'h5d:   k = 6'd6;   // ]
      8'h2b:   k = 6'd7;   // +
      8'h2d:   k = 6'd8;   // -
      8'h2a:   k = 6'd9;   // *
      8'h2f:   k = 6'd10;  // /
      8'h7c:   k = 6'd11;  // |
      8'h26:   k = 6'd12;  // &
      8'h3b:   k = 6'd13;  // ;
      8'h3a:   k = 6'd14;  // :
      8'h2c:   k = 6'd15;  // ,
      8'h2e:   k = 6'd16;  // .
      8'h3d:   k = 6'd17;  // =
      8'h3e:   k = 6'd18;  // >
      8'h3c:   k = 6'd19;  // <
      8'h21:   k = 6'd20;  // !
      default: k = KindNone;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/source_tokenizer.sv @@
// Source tokenizer top level: byte-wise lexer state and a four-entry token queue.
// Depends on srctok_pkg.
//
// Usage: source bytes enter on the s_axis channel, one per request; a zero
// byte ends the stream, yields an end token and restarts position (zero) and
// line (one) for the next stream. Tokens leave on the m_axis channel; tuser
// carries the token kind, tdata the error code, start offset, length and
// line, and tlast marks the final token caused by one source byte.
// Each byte is classified and the next lexer state computed combinationally; the
// resulting zero, one or two tokens are written into a four-entry output
// queue and are registered there before they appear on m_axis.
// Throughput is one byte per cycle while the sink takes tokens as fast as
// they appear; s_axis_tready_o is high whenever the queue has room for two
// tokens, so a byte that ends one token and emits another puts both into the
// queue at once. When the sink stalls, tokens wait in the queue and input is
// held once fewer than two entries are free. Reset empties the queue and
// returns the lexer to idle, position zero, line one.
`default_nettype none

module source_tokenizer #(
  parameter int unsigned POS_WIDTH     = 24,
  parameter int unsigned MAX_IDENT_LEN = 255,
  parameter int unsigned KEYWORD_CHARS = 6
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] source_byte
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [79:0]      m_axis_tdata_o,   // [1:0] error_code, [25:2] start_offset,
                                             // [49:26] token_length, [73:50] line_number,
                                             // [79:74] zero
  output logic [5:0]       m_axis_tuser_o,   // [5:0] token_kind
  output logic             m_axis_tlast_o    // last_of_run
);

  localparam int unsigned ExtW  = (POS_WIDTH > srctok_pkg::FieldW) ? POS_WIDTH
                                                                    : srctok_pkg::FieldW;
  localparam int unsigned WinW  = 8 * KEYWORD_CHARS;
  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = 2;

  typedef logic [POS_WIDTH-1:0] pos_t;

  function automatic logic [srctok_pkg::FieldW-1:0] sat_field(input pos_t v);
    logic [ExtW-1:0] e;
    e = ExtW'(v);
    return (e > ExtW'(srctok_pkg::FieldMax)) ? srctok_pkg::FieldMax
                                               : e[srctok_pkg::FieldW-1:0];
  endfunction

  function automatic logic [srctok_pkg::FieldW-1:0] trunc_field(input pos_t v);
    logic [ExtW-1:0] e;
    e = ExtW'(v);
    return e[srctok_pkg::FieldW-1:0];
  endfunction

  function automatic pos_t sat_inc(input pos_t v);
    return (v == '1) ? v : v + pos_t'(1);
  endfunction

  // ---------------- lexer state ----------------
  srctok_pkg::mode_e mode_q, mode_d;
  pos_t              pos_q, pos_d;
  pos_t              line_q, line_d;
  pos_t              start_q, start_d;
  logic [WinW-1:0]   window_q, window_d;
  logic              seen_q, seen_d;

  logic              in_acc;
  logic [7:0]        b;
  pos_t              len;
  srctok_pkg::tok_t  res [2];
  logic [1:0]        res_n;
  logic [5:0]        word_kind;

  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign b      = s_axis_tdata_i;
  assign len    = pos_q - start_q;

  // keyword lookup over the held identifier prefix
  always_comb begin
    word_kind = srctok_pkg::KindIdent;
    for (int w = 0; w < srctok_pkg::NumWords; w++) begin
      if (len == pos_t'(srctok_pkg::WordLen[w]) && 64'(window_q) == srctok_pkg::WordText[w]) begin
        word_kind = srctok_pkg::WordKind[w];
      end
    end
  end

  always_comb begin
    srctok_pkg::mode_e mid;
    srctok_pkg::tok_t  t;
    logic              done;
    mode_d   = mode_q;
    pos_d    = pos_q;
    line_d   = line_q;
    start_d  = start_q;
    window_d = window_q;
    seen_d   = seen_q;
    res[0]   = '0;
    res[1]   = '0;
    res_n    = 2'd0;
    mid      = mode_q;
    done     = 1'b0;
    t        = '0;
    t.line   = sat_field(line_q);

    // close an identifier or number, or extend it; a second period in a number is an error
    unique case (mode_q)
      srctok_pkg::ModeIdent: begin
        if (srctok_pkg::is_letter(b) && len < pos_t'(MAX_IDENT_LEN)) begin
          for (int k = 0; k < KEYWORD_CHARS; k++) begin
            if (len == pos_t'(k)) window_d[8*k +: 8] = b;
          end
          done = 1'b1;
        end else begin
          t.kind = word_kind;
          t.err  = srctok_pkg::ErrNone;
          t.start = trunc_field(start_q);
          t.len  = sat_field(len);
          res[0] = t;
          res_n  = 2'd1;
          mid    = srctok_pkg::ModeIdle;
        end
      end
      srctok_pkg::ModeNumber: begin
        if (srctok_pkg::is_digit(b) || (b == 8'h2e && !seen_q)) begin
          if (b == 8'h2e) seen_d = 1'b1;
          done = 1'b1;
        end else if (b == 8'h2e) begin
          t.kind  = srctok_pkg::KindError;
          t.err   = srctok_pkg::ErrTwoPeriods;
          t.start = trunc_field(pos_q);
          t.len   = '0;
          res[0]  = t;
          res_n   = 2'd1;
          mode_d  = srctok_pkg::ModeHalt;
          done    = 1'b1;
        end else begin
          t.kind  = seen_q ? srctok_pkg::KindFloat : srctok_pkg::KindInt;
          t.err   = srctok_pkg::ErrNone;
          t.start = trunc_field(start_q);
          t.len   = sat_field(len);
          res[0]  = t;
          res_n   = 2'd1;
          mid     = srctok_pkg::ModeIdle;
        end
      end
      default: ;
    endcase

    if (!done) begin
      mode_d  = mid;
      t.start = trunc_field(pos_q);
      t.len   = '0;
      t.err   = srctok_pkg::ErrNone;
      if (b == 8'h00) begin
        if (mid == srctok_pkg::ModeDstr || mid == srctok_pkg::ModeDesc ||
            mid == srctok_pkg::ModeSstr) begin
          t.kind = srctok_pkg::KindError;
          t.err  = srctok_pkg::ErrUnfinished;
          res[res_n[0]] = t;
          res_n  = res_n + 2'd1;
        end
        t.kind = srctok_pkg::KindEnd;
        t.err  = srctok_pkg::ErrNone;
        res[res_n[0]] = t;
        res_n  = res_n + 2'd1;
        // restart for the next stream
        mode_d   = srctok_pkg::ModeIdle;
        line_d   = pos_t'(1);
        start_d  = '0;
        window_d = '0;
        seen_d   = 1'b0;
      end else begin
        unique case (mid)
          srctok_pkg::ModeDstr, srctok_pkg::ModeSstr: begin
            if ((mid == srctok_pkg::ModeDstr && b == 8'h22) ||
                (mid == srctok_pkg::ModeSstr && b == 8'h27)) begin
              t.kind  = srctok_pkg::KindString;
              t.start = trunc_field(start_q);
              t.len   = sat_field(len);
              res[res_n[0]] = t;
              res_n   = res_n + 2'd1;
              mode_d  = srctok_pkg::ModeIdle;
            end else if (mid == srctok_pkg::ModeDstr && b == 8'h5c) begin
              mode_d = srctok_pkg::ModeDesc;
            end else if (srctok_pkg::is_eol(b)) begin
              line_d = sat_inc(line_q);
            end
          end
          srctok_pkg::ModeDesc: begin
            if (srctok_pkg::is_eol(b)) line_d = sat_inc(line_q);
            mode_d = srctok_pkg::ModeDstr;
          end
          srctok_pkg::ModeHalt: ;
          default: begin
            if (srctok_pkg::punct_kind(b) != srctok_pkg::KindNone) begin
              t.kind = srctok_pkg::punct_kind(b);
              t.len  = srctok_pkg::FieldW'(1);
              res[res_n[0]] = t;
              res_n  = res_n + 2'd1;
            end else if (b == 8'h22 || b == 8'h27) begin
              mode_d  = (b == 8'h22) ? srctok_pkg::ModeDstr : srctok_pkg::ModeSstr;
              start_d = sat_inc(pos_q);
            end else if (srctok_pkg::is_letter(b)) begin
              mode_d   = srctok_pkg::ModeIdent;
              start_d  = pos_q;
              window_d = WinW'(b);
            end else if (srctok_pkg::is_digit(b)) begin
              mode_d  = srctok_pkg::ModeNumber;
              start_d = pos_q;
              seen_d  = 1'b0;
            end else if (srctok_pkg::is_blank(b)) begin
              mode_d = mid;
            end else if (srctok_pkg::is_eol(b)) begin
              line_d = sat_inc(line_q);
            end else begin
              t.kind = srctok_pkg::KindError;
              t.err  = srctok_pkg::ErrUnexpected;
              res[res_n[0]] = t;
              res_n  = res_n + 2'd1;
              mode_d = srctok_pkg::ModeHalt;
            end
          end
        endcase
      end
    end

    pos_d = (!done && b == 8'h00) ? '0 : sat_inc(pos_q);
    res[0].last = (res_n == 2'd1);
    res[1].last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= srctok_pkg::ModeIdle;
      pos_q    <= '0;
      line_q   <= pos_t'(1);
      start_q  <= '0;
      window_q <= '0;
      seen_q   <= 1'b0;
    end else if (in_acc) begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      line_q   <= line_d;
      start_q  <= start_d;
      window_q <= window_d;
      seen_q   <= seen_d;
    end
  end

  // ---------------- token queue ----------------
  srctok_pkg::tok_t  mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [PtrW:0]     cnt_q;
  logic [1:0]        push_n;
  logic              pop;

  assign push_n          = in_acc ? res_n : 2'd0;
  assign pop             = m_axis_tvalid_o && m_axis_tready_i;
  assign s_axis_tready_o = (cnt_q <= (PtrW+1)'(Depth - 2));
  assign m_axis_tvalid_o = (cnt_q != '0);

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < Depth; k++) begin
      if (push_n != 2'd0 && wr_q == PtrW'(k)) mem_q[k] <= res[0];
      if (push_n == 2'd2 && wr_q + PtrW'(1) == PtrW'(k)) mem_q[k] <= res[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PtrW'(push_n);
      if (pop) rd_q <= rd_q + PtrW'(1);
      cnt_q <= cnt_q + (PtrW+1)'(push_n) - (PtrW+1)'(pop);
    end
  end

  assign m_axis_tuser_o = mem_q[rd_q].kind;
  assign m_axis_tlast_o = mem_q[rd_q].last;
  assign m_axis_tdata_o = {6'd0, mem_q[rd_q].line, mem_q[rd_q].len,
                           mem_q[rd_q].start, mem_q[rd_q].err};

  // ---------------- assertions ----------------
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(Depth))
    else $error("token queue over-filled");

  a_end_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tdata_i == 8'h00) |=> (pos_q == '0 && line_q == pos_t'(1)
                                             && cnt_q != '0))
    else $error("stream end did not restart the lexer or emit a token");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ((m_axis_tuser_o == srctok_pkg::KindError) ==
                         (m_axis_tdata_o[1:0] != srctok_pkg::ErrNone)))
    else $error("error code does not match token kind");

  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && mode_q == srctok_pkg::ModeHalt && s_axis_tdata_i != 8'h00)
      |=> (cnt_q <= $past(cnt_q) && mode_q == srctok_pkg::ModeHalt))
    else $error("halted lexer produced a token");

endmodule

`default_nettype wire
